[hw/rtl/lcdseq_pkg.sv]
`timescale 1ns / 1ps

package lcdseq_pkg;

    localparam int MAX_COLS_DEF = 40;
    localparam int QUEUE_DEPTH  = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;

    localparam logic [5:0] COLUMNS_RST = 6'd20;
    localparam logic [2:0] ROWS_RST    = 3'd4;

    typedef enum logic [3:0] {
        FUNC_INIT       = 4'd0,
        FUNC_PUT_CHAR   = 4'd1,
        FUNC_SET_CURSOR = 4'd2,
        FUNC_CLEAR      = 4'd3,
        FUNC_DISP_ON    = 4'd4,
        FUNC_DISP_OFF   = 4'd5,
        FUNC_CURS_ON    = 4'd6,
        FUNC_CURS_OFF   = 4'd7,
        FUNC_BLINK_ON   = 4'd8,
        FUNC_BLINK_OFF  = 4'd9,
        FUNC_SCROLL_L   = 4'd10,
        FUNC_SCROLL_R   = 4'd11,
        FUNC_CGRAM      = 4'd12,
        FUNC_RAW        = 4'd13
    } t_func;

    localparam logic [7:0] CHAR_NL       = 8'h0A;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h04;
    localparam logic [7:0] ENTRY_INC     = 8'h02;
    localparam logic [7:0] CMD_DISPLAY   = 8'h08;
    localparam logic [7:0] CMD_SHIFT     = 8'h10;
    localparam logic [7:0] SHIFT_DISPLAY = 8'h08;
    localparam logic [7:0] SHIFT_RIGHT   = 8'h04;
    localparam logic [7:0] CMD_FUNC      = 8'h20;
    localparam logic [7:0] FUNC_2LINE    = 8'h08;
    localparam logic [7:0] CMD_CGRAM     = 8'h40;
    localparam logic [7:0] CMD_DDRAM     = 8'h80;

    localparam logic [2:0] FLAG_DISPLAY = 3'h4;
    localparam logic [2:0] FLAG_CURSOR  = 3'h2;
    localparam logic [2:0] FLAG_BLINK   = 3'h1;

    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;
    localparam logic [3:0] INIT_WAKE_LAST = 4'd3;
    localparam logic [3:0] INIT_LAST = 4'd11;

    typedef struct packed {
        logic [3:0] func;
        logic [7:0] char_code;
        logic [5:0] column;
        logic [1:0] row;
        logic [2:0] slot;
    } t_item;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic       last;
    } t_result;

    // one queued job: the init sequence, or one or two bytes
    typedef struct packed {
        logic       is_init;
        logic       two;
        logic       rs0;
        logic [7:0] byte0;
        logic       rs1;
        logic [7:0] byte1;
    } t_job;

    function automatic logic [6:0] row_base(input logic [1:0] row);
        logic [6:0] base;
        unique case (row)
            2'd0: base = 7'h00;
            2'd1: base = 7'h40;
            2'd2: base = 7'h14;
            2'd3: base = 7'h54;
            default: base = 7'h00;
        endcase
        return base;
    endfunction

    function automatic logic [7:0] ddram_cmd(input logic [5:0] col, input logic [1:0] row);
        logic [6:0] addr;
        addr = 7'({1'b0, col} + row_base(row));
        return CMD_DDRAM | {1'b0, addr};
    endfunction

    // command bytes of init after the wake nibbles
    function automatic logic [7:0] init_byte(input logic [1:0] k, input logic two_line);
        logic [7:0] b;
        unique case (k)
            2'd0: b = two_line ? (CMD_FUNC | FUNC_2LINE) : CMD_FUNC;
            2'd1: b = CMD_DISPLAY | {5'd0, FLAG_DISPLAY};
            2'd2: b = CMD_CLEAR;
            2'd3: b = CMD_ENTRY | ENTRY_INC;
            default: b = CMD_CLEAR;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/char_lcd_nibble_command_sequencer_top.sv]
`timescale 1ns / 1ps

// channel   | handshake             | payload
// ----------+-----------------------+--------------------------------------
// command   | push / full           | i_item   (func, char_code, column,
//           |                       |           row, slot)
// transfer  | empty / pop           | o_result (reg_select, nibble, last)
// config    | i_cfg_we, i_cfg_idx   | i_cfg_data (columns, rows_in_use)
//
// a command is taken whenever the two-entry job queue has room;
// the nibble sequencer then sends one transfer per cycle while pop is held high: two for most
// commands, two to four for a character, twelve for init.
// a command with no transfers (unused codes) is taken but queues no job.
// synchronous reset clears cursor, flags and the queue and restores the
// configuration defaults; a command is taken in the first cycle after reset.
// pop held low stalls the sequencer, the queue then fills and raises full.

module char_lcd_nibble_command_sequencer_top #(
    parameter int MAX_COLS = lcdseq_pkg::MAX_COLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [5:0]           i_cfg_data,
    input  logic                 push,
    output logic                 full,
    input  lcdseq_pkg::t_item    i_item,
    output logic                 empty,
    input  logic                 pop,
    output lcdseq_pkg::t_result  o_result
);

    logic              accept;
    logic              job_push;
    lcdseq_pkg::t_job  job_in;
    logic              job_valid;
    logic              job_take;
    lcdseq_pkg::t_job  job_out;

    assign accept = push && !full;

    lcdseq_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    lcdseq_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (job_push),
        .i_wr_data  (job_in),
        .o_full     (full),
        .i_rd_en    (job_take),
        .o_rd_valid (job_valid),
        .o_rd_data  (job_out)
    );

    lcdseq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_take  (job_take),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

[hw/rtl/lcdseq_front.sv]
`timescale 1ns / 1ps

module lcdseq_front #(
    parameter int MAX_COLS = lcdseq_pkg::MAX_COLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [5:0]           i_cfg_data,
    input  logic                 i_accept,
    input  lcdseq_pkg::t_item    i_item,
    output logic                 o_job_push,
    output lcdseq_pkg::t_job     o_job
);

    localparam logic [5:0] MaxCols = 6'(MAX_COLS);

    logic [5:0] r_columns;
    logic [2:0] r_rows;
    logic [5:0] r_col, n_col;
    logic [1:0] r_row, n_row;
    logic [2:0] r_flags, n_flags;

    logic [5:0] ncols;
    logic       wrap;
    logic [5:0] c1;
    logic [1:0] w1;
    logic [1:0] row_nl;
    logic [1:0] row_cr;
    logic [1:0] set_row;
    logic [7:0] second;
    logic       second_rs;
    logic       job_valid;

    function automatic logic [1:0] next_row(input logic [1:0] row, input logic [2:0] rows);
        logic [2:0] r1;
        r1 = {1'b0, row} + 3'd1;
        if (r1 >= rows || r1 > 3'd3) begin
            return 2'd0;
        end
        return r1[1:0];
    endfunction

    assign ncols   = (r_columns > MaxCols) ? MaxCols : r_columns;
    assign wrap    = (r_col >= ncols);
    assign c1      = wrap ? 6'd0 : r_col;
    assign w1      = wrap ? next_row(r_row, r_rows) : r_row;
    assign row_nl  = next_row(w1, r_rows);
    // a row left beyond the row count by a later configuration goes to the top
    assign row_cr  = ({1'b0, w1} >= r_rows) ? 2'd0 : w1;
    assign set_row = ({1'b0, i_item.row} >= r_rows) ? 2'd0 : i_item.row;

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_flags   = r_flags;
        job_valid = 1'b1;
        second    = i_item.char_code;
        second_rs = 1'b1;
        o_job     = '0;
        unique case (lcdseq_pkg::t_func'(i_item.func))
            lcdseq_pkg::FUNC_INIT: begin
                n_col         = 6'd0;
                n_row         = 2'd0;
                n_flags       = lcdseq_pkg::FLAG_DISPLAY;
                o_job.is_init = 1'b1;
                o_job.byte0   = lcdseq_pkg::init_byte(2'd0, r_rows > 3'd1);
            end
            lcdseq_pkg::FUNC_PUT_CHAR: begin
                if (i_item.char_code == lcdseq_pkg::CHAR_NL) begin
                    n_col     = c1;
                    n_row     = row_nl;
                    second    = lcdseq_pkg::ddram_cmd(c1, row_nl);
                    second_rs = 1'b0;
                end else if (i_item.char_code == lcdseq_pkg::CHAR_CR) begin
                    n_col     = 6'd0;
                    n_row     = row_cr;
                    second    = lcdseq_pkg::ddram_cmd(6'd0, row_cr);
                    second_rs = 1'b0;
                end else begin
                    n_col = c1 + 6'd1;
                    n_row = w1;
                end
                // a wrap puts a cursor move ahead of the character action
                if (wrap) begin
                    o_job.two   = 1'b1;
                    o_job.byte0 = lcdseq_pkg::ddram_cmd(6'd0, w1);
                    o_job.rs1   = second_rs;
                    o_job.byte1 = second;
                end else begin
                    o_job.rs0   = second_rs;
                    o_job.byte0 = second;
                end
            end
            lcdseq_pkg::FUNC_SET_CURSOR: begin
                n_col       = i_item.column;
                n_row       = set_row;
                o_job.byte0 = lcdseq_pkg::ddram_cmd(i_item.column, set_row);
            end
            lcdseq_pkg::FUNC_CLEAR: begin
                o_job.byte0 = lcdseq_pkg::CMD_CLEAR;
            end
            lcdseq_pkg::FUNC_DISP_ON, lcdseq_pkg::FUNC_DISP_OFF,
            lcdseq_pkg::FUNC_CURS_ON, lcdseq_pkg::FUNC_CURS_OFF,
            lcdseq_pkg::FUNC_BLINK_ON, lcdseq_pkg::FUNC_BLINK_OFF: begin
                unique case (lcdseq_pkg::t_func'(i_item.func))
                    lcdseq_pkg::FUNC_DISP_ON:   n_flags = r_flags | lcdseq_pkg::FLAG_DISPLAY;
                    lcdseq_pkg::FUNC_DISP_OFF:  n_flags = r_flags & ~lcdseq_pkg::FLAG_DISPLAY;
                    lcdseq_pkg::FUNC_CURS_ON:   n_flags = r_flags | lcdseq_pkg::FLAG_CURSOR;
                    lcdseq_pkg::FUNC_CURS_OFF:  n_flags = r_flags & ~lcdseq_pkg::FLAG_CURSOR;
                    lcdseq_pkg::FUNC_BLINK_ON:  n_flags = r_flags | lcdseq_pkg::FLAG_BLINK;
                    default:                    n_flags = r_flags & ~lcdseq_pkg::FLAG_BLINK;
                endcase
                o_job.byte0 = lcdseq_pkg::CMD_DISPLAY | {5'd0, n_flags};
            end
            lcdseq_pkg::FUNC_SCROLL_L: begin
                o_job.byte0 = lcdseq_pkg::CMD_SHIFT | lcdseq_pkg::SHIFT_DISPLAY;
            end
            lcdseq_pkg::FUNC_SCROLL_R: begin
                o_job.byte0 = lcdseq_pkg::CMD_SHIFT | lcdseq_pkg::SHIFT_DISPLAY
                            | lcdseq_pkg::SHIFT_RIGHT;
            end
            lcdseq_pkg::FUNC_CGRAM: begin
                o_job.byte0 = lcdseq_pkg::CMD_CGRAM | {2'b00, i_item.slot, 3'b000};
            end
            lcdseq_pkg::FUNC_RAW: begin
                o_job.rs0   = 1'b1;
                o_job.byte0 = i_item.char_code;
            end
            default: begin
                // unused codes cause no transfer
                job_valid = 1'b0;
            end
        endcase
    end

    assign o_job_push = i_accept && job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= lcdseq_pkg::COLUMNS_RST;
            r_rows    <= lcdseq_pkg::ROWS_RST;
            r_col     <= 6'd0;
            r_row     <= 2'd0;
            r_flags   <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lcdseq_pkg::CFG_COLUMNS: r_columns <= i_cfg_data;
                    lcdseq_pkg::CFG_ROWS:    r_rows    <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_flags <= n_flags;
            end
        end
    end

endmodule

[hw/rtl/lcdseq_queue.sv]
`timescale 1ns / 1ps

module lcdseq_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  lcdseq_pkg::t_job  i_wr_data,
    output logic              o_full,
    input  logic              i_rd_en,
    output logic              o_rd_valid,
    output lcdseq_pkg::t_job  o_rd_data
);

    localparam int Depth  = lcdseq_pkg::QUEUE_DEPTH;
    localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    lcdseq_pkg::t_job r_mem [Depth];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CountW-1:0] r_count;
    logic              do_wr;
    logic              do_rd;

    assign o_full     = (r_count == CountW'(Depth));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign do_wr      = i_wr_en && !o_full;
    assign do_rd      = i_rd_en && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/lcdseq_back.sv]
`timescale 1ns / 1ps

module lcdseq_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  lcdseq_pkg::t_job     i_job,
    output logic                 o_job_take,
    output logic                 empty,
    input  logic                 pop,
    output lcdseq_pkg::t_result  o_result
);

    logic                 r_busy;
    lcdseq_pkg::t_job     r_job;
    logic [3:0]           r_idx;
    logic                 r_out_valid;
    lcdseq_pkg::t_result  r_out;

    lcdseq_pkg::t_result  cur;
    logic [7:0]           cur_byte;
    logic [3:0]           init_off;
    logic                 advance;

    always_comb begin
        init_off = 4'(r_idx - 4'd4);
        cur      = '0;
        cur_byte = '0;
        if (r_job.is_init) begin
            if (r_idx <= lcdseq_pkg::INIT_WAKE_LAST) begin
                cur.nibble = (r_idx == lcdseq_pkg::INIT_WAKE_LAST) ? lcdseq_pkg::NIB_4BIT
                                                                  : lcdseq_pkg::NIB_WAKE;
            end else begin
                // function set byte was chosen at the front from the row count
                cur_byte   = (init_off[2:1] == 2'd0) ? r_job.byte0
                                                     : lcdseq_pkg::init_byte(init_off[2:1], 1'b0);
                cur.nibble = init_off[0] ? cur_byte[3:0] : cur_byte[7:4];
            end
            cur.last = (r_idx == lcdseq_pkg::INIT_LAST);
        end else begin
            cur_byte       = r_idx[1] ? r_job.byte1 : r_job.byte0;
            cur.reg_select = r_idx[1] ? r_job.rs1 : r_job.rs0;
            cur.nibble     = r_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
            cur.last       = (r_idx == {2'b00, r_job.two, 1'b1});
        end
    end

    assign advance    = !r_out_valid || pop;
    assign o_job_take = i_job_valid && (!r_busy || (advance && cur.last));
    assign empty      = !r_out_valid;
    assign o_result   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= 4'd0;
        end else begin
            if (advance) begin
                r_out_valid <= r_busy;
                if (r_busy) begin
                    r_idx <= r_idx + 4'd1;
                    if (cur.last) begin
                        r_busy <= 1'b0;
                    end
                end
            end
            if (o_job_take) begin
                r_busy <= 1'b1;
                r_idx  <= 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= cur;
        end
        if (o_job_take) begin
            r_job <= i_job;
        end
    end

endmodule

[hw/rtl/lcdseq_chk.sv]
`timescale 1ns / 1ps

module lcdseq_chk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 full,
    input  logic                 empty,
    input  logic                 pop,
    input  lcdseq_pkg::t_result  o_result
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_reset_room: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("command side full after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting transfer changed or vanished");

    // the nibbles of one command follow each other with no gap
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_result.last) |=> !empty)
        else $error("gap inside the transfers of one command");

endmodule

bind char_lcd_nibble_command_sequencer_top lcdseq_chk u_lcdseq_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

[tb/char_lcd_nibble_command_sequencer_top_test.sv]
`timescale 1ns / 1ps

module char_lcd_nibble_command_sequencer_top_test;

    import lcdseq_pkg::*;

    localparam int          IDLE_PCT    = 27;
    localparam int          SETTLE      = 6;
    localparam int          STALL_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [3:0]  FUNC_SPARE_A = 4'd14;
    localparam logic [3:0]  FUNC_SPARE_B = 4'd15;
    localparam logic [6:0]  ROW_ADDR [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [5:0]  i_cfg_data;
    logic        push;
    logic        full;
    t_item       i_item;
    logic        empty;
    logic        pop;
    t_result     o_result;

    char_lcd_nibble_command_sequencer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

    // shadow of the block: configuration, cursor and control flags
    logic [5:0] cfg_cols;
    logic [2:0] cfg_rows;
    logic [5:0] cur_col;
    logic [1:0] cur_row;
    logic [2:0] ctrl_flags;

    t_result    item_xfers[$];
    t_result    due_xfers[$];
    int         bad_xfers;
    bit         steady;
    int         hold_left;
    int         quiet_run;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void add_nibble(input logic rs, input logic [3:0] nib);
        t_result r;
        r.reg_select = rs;
        r.nibble     = nib;
        r.last       = 1'b0;
        item_xfers.push_back(r);
    endfunction

    function automatic void add_byte(input logic rs, input logic [7:0] b);
        add_nibble(rs, b[7:4]);
        add_nibble(rs, b[3:0]);
    endfunction

    function automatic void move_cursor(input int col, input int row);
        logic [6:0] addr;
        if (row >= cfg_rows || row > 3)
            row = 0;
        cur_col = col[5:0];
        cur_row = row[1:0];
        addr = 7'({1'b0, cur_col} + ROW_ADDR[cur_row]);
        add_byte(1'b0, CMD_DDRAM | {1'b0, addr});
    endfunction

    function automatic void change_flag(input logic [2:0] mask, input bit on);
        if (on)
            ctrl_flags = ctrl_flags | mask;
        else
            ctrl_flags = ctrl_flags & ~mask;
        add_byte(1'b0, CMD_DISPLAY | {5'd0, ctrl_flags});
    endfunction

    function automatic void predict_transfers(input t_item it);
        int      ncols;
        t_result r;
        ncols = (cfg_cols > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cfg_cols);
        item_xfers.delete();
        case (it.func)
            FUNC_INIT: begin
                cur_col = '0;
                cur_row = '0;
                add_nibble(1'b0, NIB_WAKE);
                add_nibble(1'b0, NIB_WAKE);
                add_nibble(1'b0, NIB_WAKE);
                add_nibble(1'b0, NIB_4BIT);
                add_byte(1'b0, (cfg_rows > 3'd1) ? (CMD_FUNC | FUNC_2LINE) : CMD_FUNC);
                ctrl_flags = FLAG_DISPLAY;
                add_byte(1'b0, CMD_DISPLAY | {5'd0, ctrl_flags});
                add_byte(1'b0, CMD_CLEAR);
                add_byte(1'b0, CMD_ENTRY | ENTRY_INC);
            end
            FUNC_PUT_CHAR: begin
                // past the last column: wrap to the next row first
                if (cur_col >= ncols)
                    move_cursor(0, int'(cur_row) + 1);
                if (it.char_code == CHAR_NL)
                    move_cursor(cur_col, int'(cur_row) + 1);
                else if (it.char_code == CHAR_CR)
                    move_cursor(0, cur_row);
                else begin
                    add_byte(1'b1, it.char_code);
                    cur_col = cur_col + 6'd1;
                end
            end
            FUNC_SET_CURSOR: move_cursor(it.column, it.row);
            FUNC_CLEAR:      add_byte(1'b0, CMD_CLEAR);
            FUNC_DISP_ON:    change_flag(FLAG_DISPLAY, 1'b1);
            FUNC_DISP_OFF:   change_flag(FLAG_DISPLAY, 1'b0);
            FUNC_CURS_ON:    change_flag(FLAG_CURSOR, 1'b1);
            FUNC_CURS_OFF:   change_flag(FLAG_CURSOR, 1'b0);
            FUNC_BLINK_ON:   change_flag(FLAG_BLINK, 1'b1);
            FUNC_BLINK_OFF:  change_flag(FLAG_BLINK, 1'b0);
            FUNC_SCROLL_L:   add_byte(1'b0, CMD_SHIFT | SHIFT_DISPLAY);
            FUNC_SCROLL_R:   add_byte(1'b0, CMD_SHIFT | SHIFT_DISPLAY | SHIFT_RIGHT);
            FUNC_CGRAM:      add_byte(1'b0, CMD_CGRAM | {2'd0, it.slot, 3'd0});
            FUNC_RAW:        add_byte(1'b1, it.char_code);
            default: ;
        endcase
        foreach (item_xfers[i]) begin
            r = item_xfers[i];
            r.last = (i == item_xfers.size() - 1);
            due_xfers.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic t_item make_cmd(input logic [3:0] f, input logic [7:0] ch = '0,
                                       input logic [5:0] col = '0, input logic [1:0] row = '0,
                                       input logic [2:0] slot = '0);
        t_item it;
        it.func      = f;
        it.char_code = ch;
        it.column    = col;
        it.row       = row;
        it.slot      = slot;
        return it;
    endfunction

    // mostly text with line control, the rest commands and a few unused codes
    function automatic t_item rand_cmd();
        t_item it;
        int    pick;
        int    chp;
        it.char_code = 8'($urandom_range(0, 255));
        it.column    = 6'($urandom_range(0, 63));
        it.row       = 2'($urandom_range(0, 3));
        it.slot      = 3'($urandom_range(0, 7));
        chp  = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        if (chp < 10)
            it.char_code = CHAR_NL;
        else if (chp < 18)
            it.char_code = CHAR_CR;
        if (pick < 50)
            it.func = FUNC_PUT_CHAR;
        else if (pick < 62)
            it.func = FUNC_SET_CURSOR;
        else if (pick < 66)
            it.func = FUNC_CLEAR;
        else if (pick < 78)
            it.func = 4'($urandom_range(FUNC_DISP_ON, FUNC_BLINK_OFF));
        else if (pick < 84)
            it.func = $urandom_range(0, 1) ? FUNC_SCROLL_L : FUNC_SCROLL_R;
        else if (pick < 89)
            it.func = FUNC_CGRAM;
        else if (pick < 96)
            it.func = FUNC_RAW;
        else if (pick < 98)
            it.func = FUNC_INIT;
        else
            it.func = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
        return it;
    endfunction

    task automatic send_cmd(input t_item it);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        @(negedge i_clk);
        while (gap > 0) begin
            push <= 1'b0;
            gap--;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do
            @(posedge i_clk);
        while (full);
        predict_transfers(it);
    endtask

    // returns once every predicted transfer has come out and the block is quiet
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (due_xfers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
        drain();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_COLUMNS)
            cfg_cols = data;
        else if (idx == CFG_ROWS)
            cfg_rows = data[2:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // send n random commands that produce transfers; unused codes come on top
    task automatic send_random(input int n);
        t_item it;
        int    sent;
        sent = 0;
        while (sent < n) begin
            it = rand_cmd();
            send_cmd(it);
            if (it.func != FUNC_SPARE_A && it.func != FUNC_SPARE_B)
                sent++;
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        send_cmd(make_cmd(FUNC_INIT));
        send_cmd(make_cmd(FUNC_PUT_CHAR, 8'h41));
        send_cmd(make_cmd(FUNC_PUT_CHAR, 8'h00));
        send_cmd(make_cmd(FUNC_PUT_CHAR, 8'hFF));
        send_cmd(make_cmd(FUNC_PUT_CHAR, CHAR_NL));
        send_cmd(make_cmd(FUNC_PUT_CHAR, CHAR_CR));
        // column beyond the row length forces a wrap on the next character
        send_cmd(make_cmd(FUNC_SET_CURSOR, 8'h00, 6'd63, 2'd3));
        send_cmd(make_cmd(FUNC_PUT_CHAR, 8'h78));
        // last column of the last row, then wrap back to the top row
        send_cmd(make_cmd(FUNC_SET_CURSOR, 8'h00, 6'd19, 2'd3));
        send_cmd(make_cmd(FUNC_PUT_CHAR, 8'h42));
        send_cmd(make_cmd(FUNC_PUT_CHAR, 8'h43));
        send_cmd(make_cmd(FUNC_SET_CURSOR, 8'h00, 6'd39, 2'd0));
        send_cmd(make_cmd(FUNC_CLEAR));
        send_cmd(make_cmd(FUNC_DISP_ON));
        send_cmd(make_cmd(FUNC_DISP_OFF));
        send_cmd(make_cmd(FUNC_CURS_ON));
        send_cmd(make_cmd(FUNC_BLINK_ON));
        send_cmd(make_cmd(FUNC_CURS_OFF));
        send_cmd(make_cmd(FUNC_BLINK_OFF));
        send_cmd(make_cmd(FUNC_SCROLL_L));
        send_cmd(make_cmd(FUNC_SCROLL_R));
        send_cmd(make_cmd(FUNC_CGRAM, 8'h00, 6'd0, 2'd0, 3'd0));
        send_cmd(make_cmd(FUNC_CGRAM, 8'h00, 6'd0, 2'd0, 3'd7));
        send_cmd(make_cmd(FUNC_RAW, 8'h00));
        send_cmd(make_cmd(FUNC_RAW, 8'hFF));
        send_cmd(make_cmd(FUNC_SPARE_A));
        send_cmd(make_cmd(FUNC_SPARE_B));
        send_cmd(make_cmd(FUNC_PUT_CHAR, 8'h5A));
    endtask

    // zero columns wraps before every character, above the limit saturates,
    // zero rows send every row change to the top row, oversize rows wrap after row 3
    task automatic test_geometry_sweep();
        logic [5:0] col_set [6] = '{6'd1, 6'd40, 6'd0, 6'd63, 6'd8, 6'd16};
        logic [5:0] row_set [6] = '{6'd1, 6'd4, 6'd2, 6'd3, 6'd7, 6'd0};
        foreach (col_set[k]) begin
            write_reg(CFG_COLUMNS, col_set[k]);
            write_reg(CFG_ROWS, row_set[k]);
            steady = (k == 2);
            send_cmd(make_cmd(FUNC_INIT));
            send_random(68);
        end
        steady = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering: input must stall
    task automatic test_output_hold();
        write_reg(CFG_COLUMNS, 6'd20);
        write_reg(CFG_ROWS, 6'd4);
        steady    = 1'b1;
        hold_left = HOLD_CYCLES;
        send_random(40);
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- output side

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left = hold_left - 1;
        end else if (steady) begin
            pop <= 1'b1;
        end else begin
            pop <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    logic    took;
    t_result got;
    t_result want;

    always begin
        @(posedge i_clk);
        took = i_rst_n && pop && !empty;
        got  = o_result;
        // let the sender's prediction for this edge land first
        #1;
        if (took) begin
            if (due_xfers.size() == 0) begin
                $error("unexpected transfer rs=%0b nibble=%h last=%0b",
                       got.reg_select, got.nibble, got.last);
                bad_xfers++;
            end else begin
                want = due_xfers.pop_front();
                if (got.reg_select !== want.reg_select) begin
                    $error("reg_select: expected %0b, got %0b", want.reg_select, got.reg_select);
                    bad_xfers++;
                end
                if (got.nibble !== want.nibble) begin
                    $error("nibble: expected %h, got %h", want.nibble, got.nibble);
                    bad_xfers++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, got.last);
                    bad_xfers++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            quiet_run = 0;
        else
            quiet_run = quiet_run + 1;
        if (quiet_run >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        push       = 1'b0;
        pop        = 1'b0;
        i_item     = '0;
        steady     = 1'b0;
        hold_left  = 0;
        quiet_run  = 0;
        bad_xfers  = 0;
        cfg_cols   = COLUMNS_RST;
        cfg_rows   = ROWS_RST;
        cur_col    = '0;
        cur_row    = '0;
        ctrl_flags = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_geometry_sweep();
        test_output_hold();

        drain();
        repeat (SETTLE * 4) @(posedge i_clk);
        if (bad_xfers == 0 && due_xfers.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
